// File: rtl/tts_pkg.sv
// Shared types and byte constants for the template-to-script translator.
// No dependencies; imported by every other file of the block but tts_stream_if.
package tts_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_done;
      logic       stream_done;
   } rsp_payload_type;

   // One classified input byte: which output segments to play, in this order:
   // run header, tag prefix, escaped literal, run close, '?', raw byte, '?', newline.
   typedef struct packed {
      logic       head;
      logic [2:0] pfx_len;
      logic       lit;
      logic       close;
      logic       q1;
      logic       raw;
      logic       q2;
      logic       nl;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   localparam logic [7:0] CH_LT    = 8'h3C;  // <
   localparam logic [7:0] CH_QM    = 8'h3F;  // ?
   localparam logic [7:0] CH_V     = 8'h76;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_GT    = 8'h3E;  // >
   localparam logic [7:0] CH_LBR   = 8'h7B;  // {
   localparam logic [7:0] CH_RBR   = 8'h7D;  // }
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Opening tag byte at a given match position.
   function automatic logic [7:0] open_tag_byte(input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0:    b = CH_LT;
         3'd1:    b = CH_QM;
         3'd2:    b = CH_V;
         3'd3:    b = CH_E;
         3'd4:    b = CH_L;
         default: b = CH_LT;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/tts_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload type is set per instance.
interface tts_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tts_front.sv
// Front end: accepts template bytes, tracks tag matching and mode, and turns
// each byte into a segment command. Depends on tts_pkg.
module tts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tts_pkg::req_payload_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output tts_pkg::cmd_type  q_cmd
);
   import tts_pkg::*;

   logic       code_ff, code_in;
   logic       run_ff, run_in;
   logic [2:0] match_ff, match_in;
   logic       qpend_ff, qpend_in;
   logic       accept;
   logic       matched;
   logic [7:0] b;
   cmd_type    cmd;

   assign b         = req_data.in_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      cmd.data = b;
      cmd.last = req_data.in_last;
      code_in  = code_ff;
      run_in   = run_ff;
      match_in = match_ff;
      qpend_in = qpend_ff;
      matched  = 1'b0;
      if (code_ff) begin
         if (qpend_ff && b == CH_GT) begin
            cmd.nl   = 1'b1;
            code_in  = 1'b0;
            qpend_in = 1'b0;
         end else begin
            cmd.q1 = qpend_ff;
            if (b == CH_QM) begin
               qpend_in = 1'b1;
            end else begin
               cmd.raw  = 1'b1;
               qpend_in = 1'b0;
            end
         end
      end else begin
         if (b == open_tag_byte(match_ff)) begin
            if (match_ff == 3'd4) begin
               cmd.close = run_ff;
               run_in    = 1'b0;
               code_in   = 1'b1;
               qpend_in  = 1'b0;
               match_in  = 3'd0;
            end else begin
               matched  = 1'b1;
               match_in = match_ff + 3'd1;
            end
         end else begin
            // flush the failed prefix, then retry on this byte
            cmd.pfx_len = match_ff;
            if (b == CH_LT) begin
               cmd.head = !run_ff && (match_ff != 3'd0);
               run_in   = run_ff || (match_ff != 3'd0);
               match_in = 3'd1;
            end else begin
               cmd.head = !run_ff;
               cmd.lit  = 1'b1;
               run_in   = 1'b1;
               match_in = 3'd0;
            end
         end
      end
      if (req_data.in_last) begin
         if (code_in) begin
            cmd.q2 = qpend_in;
            cmd.nl = 1'b1;
         end else begin
            if (match_in != 3'd0) begin
               if (matched) begin
                  cmd.pfx_len = match_in;
               end else begin
                  cmd.lit = 1'b1;
               end
               cmd.head = cmd.head || !run_in;
            end
            cmd.close = run_in || (match_in != 3'd0);
         end
         code_in  = 1'b0;
         run_in   = 1'b0;
         match_in = 3'd0;
         qpend_in = 1'b0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.head || cmd.pfx_len != 3'd0 || cmd.lit || cmd.close ||
                              cmd.q1 || cmd.raw || cmd.q2 || cmd.nl);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= 1'b0;
         run_ff   <= 1'b0;
         match_ff <= 3'd0;
         qpend_ff <= 1'b0;
      end else if (accept) begin
         code_ff  <= code_in;
         run_ff   <= run_in;
         match_ff <= match_in;
         qpend_ff <= qpend_in;
      end
   end

endmodule

// File: rtl/tts_queue.sv
// Small command queue between front and back end, flop based.
// Depends on tts_pkg for the command type.
module tts_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tts_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tts_pkg::cmd_type head_cmd
);
   import tts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_cmd  = slot_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/tts_back.sv
// Back end: plays out the segments of each queued command one byte per
// cycle, while the output is not stalled, into an output register. Depends on tts_pkg.
module tts_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_not_empty,
   input  tts_pkg::cmd_type          q_cmd,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tts_pkg::rsp_payload_type  rsp_data
);
   import tts_pkg::*;

   localparam logic [2:0] PH_HEAD  = 3'd0;
   localparam logic [2:0] PH_PFX   = 3'd1;
   localparam logic [2:0] PH_LIT   = 3'd2;
   localparam logic [2:0] PH_CLOSE = 3'd3;
   localparam logic [2:0] PH_Q1    = 3'd4;
   localparam logic [2:0] PH_RAW   = 3'd5;
   localparam logic [2:0] PH_Q2    = 3'd6;
   localparam logic [2:0] PH_NL    = 3'd7;

   function automatic logic [7:0] seg_mask(input cmd_type c);
      return {c.nl, c.q2, c.raw, c.q1, c.close, c.lit, c.pfx_len != 3'd0, c.head};
   endfunction

   function automatic logic [2:0] lowest_bit(input logic [7:0] m);
      logic [2:0] p;
      p = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (m[i]) p = 3'(i);
      end
      return p;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == CH_LBR) || (b == CH_RBR) || (b == CH_DQ) || (b == CH_BSL);
   endfunction

   function automatic logic [7:0] head_byte(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = CH_NL;
         3'd1:    r = CH_W;
         3'd2:    r = CH_R;
         3'd3:    r = CH_I;
         3'd4:    r = CH_T;
         3'd5:    r = CH_E;
         3'd6:    r = CH_SP;
         3'd7:    r = CH_DQ;
         default: r = CH_NL;
      endcase
      return r;
   endfunction

   cmd_type    cmd_ff;
   logic       cur_vld_ff, cur_vld_in;
   logic [2:0] ph_ff, ph_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_vld_ff, out_vld_in;
   rsp_payload_type out_ff, out_in;

   logic       load_en, emit, ph_end, fin;
   logic [2:0] last_idx;
   logic [7:0] above, next_mask;
   logic [7:0] cur_byte;

   assign load_en = !out_vld_ff || rsp_ready;
   assign emit    = cur_vld_ff && load_en;

   always_comb begin
      last_idx = 3'd0;
      cur_byte = cmd_ff.data;
      case (ph_ff)
         PH_HEAD: begin
            last_idx = 3'd7;
            cur_byte = head_byte(idx_ff);
         end
         PH_PFX: begin
            last_idx = cmd_ff.pfx_len - 3'd1;
            cur_byte = open_tag_byte(idx_ff);
         end
         PH_LIT: begin
            last_idx = {2'b00, needs_escape(cmd_ff.data)};
            if (needs_escape(cmd_ff.data) && idx_ff == 3'd0) begin
               cur_byte = CH_BSL;
            end else if (cmd_ff.data == CH_LBR) begin
               cur_byte = CH_O;
            end else if (cmd_ff.data == CH_RBR) begin
               cur_byte = CH_C;
            end else begin
               cur_byte = cmd_ff.data;
            end
         end
         PH_CLOSE: begin
            last_idx = 3'd1;
            cur_byte = (idx_ff == 3'd0) ? CH_DQ : CH_NL;
         end
         PH_Q1:    cur_byte = CH_QM;
         PH_RAW:   cur_byte = cmd_ff.data;
         PH_Q2:    cur_byte = CH_QM;
         PH_NL:    cur_byte = CH_NL;
         default:  cur_byte = cmd_ff.data;
      endcase
   end

   assign above     = 8'hFE << ph_ff;
   assign next_mask = seg_mask(cmd_ff) & above;
   assign ph_end    = (idx_ff == last_idx);
   assign fin       = ph_end && (next_mask == 8'd0);
   assign q_pop     = q_not_empty && (!cur_vld_ff || (emit && fin));

   always_comb begin
      cur_vld_in = cur_vld_ff;
      ph_in      = ph_ff;
      idx_in     = idx_ff;
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (load_en) begin
         out_vld_in = cur_vld_ff;
      end
      if (emit) begin
         out_in.out_byte    = cur_byte;
         out_in.item_done   = fin;
         out_in.stream_done = fin && cmd_ff.last;
         if (ph_end) begin
            ph_in  = lowest_bit(next_mask);
            idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
         if (fin) begin
            cur_vld_in = 1'b0;
         end
      end
      if (q_pop) begin
         cur_vld_in = 1'b1;
         ph_in      = lowest_bit(seg_mask(q_cmd));
         idx_in     = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         ph_ff      <= PH_HEAD;
         idx_ff     <= 3'd0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
         ph_ff      <= ph_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/template_tag_to_script_translator_top.sv
// Channel   Dir  Payload                                 Accepted when
// req_ch    in   in_byte[7:0], in_last                   req_ch.valid && req_ch.ready
// rsp_ch    out  out_byte[7:0], item_done, stream_done   rsp_ch.valid && rsp_ch.ready
//
// A byte is classified in the cycle it is accepted; its output bytes leave one per
// cycle from the back end while rsp_ch is not stalled, 0 to 16 per input byte, so
// throughput is set by the back end's single output byte per cycle.
// Reset is synchronous and returns tag matching and mode to literal text.
// The command queue (QUEUE_DEPTH entries) lets input and output stall independently.
// Depends on tts_pkg, tts_stream_if, tts_front, tts_queue, tts_back.
module template_tag_to_script_translator_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   tts_stream_if.sink    req_ch,
   tts_stream_if.source  rsp_ch
);
   import tts_pkg::*;

   logic    q_push, q_full, q_pop, q_not_empty;
   cmd_type push_cmd, head_cmd;
   rsp_payload_type rsp_data;
   req_payload_type req_data;

   assign req_data = req_ch.payload;

   tts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   tts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   tts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_ch.payload = rsp_data;

   // never push a transaction into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into full queue");

   // end of stream is always the last byte of its input byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_data.stream_done |-> rsp_data.item_done)
      else $error("stream_done without item_done");

   // no output straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("output valid right after reset");

   // a popped command is only taken when the queue holds one
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule
